// ===== hw/rtl/bsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded shift deque package
// Request and response payload types, operation and status codes, and the
// per-cell control word shared by the deque's cell row and its top level.
// ----------------------------------------------------------------------------
package bsd_pkg;

   // Operation codes carried in the kind field of a request.
   localparam logic [2:0] KIND_PUSH_HEAD = 3'd0;
   localparam logic [2:0] KIND_PUSH_TAIL = 3'd1;
   localparam logic [2:0] KIND_POP_HEAD  = 3'd2;
   localparam logic [2:0] KIND_POP_TAIL  = 3'd3;
   localparam logic [2:0] KIND_READ      = 3'd4;

   // Status codes returned with every response.
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;
   localparam logic [1:0] STATUS_RANGE = 2'd3;

   // Width of the element fields on the ports.
   localparam int unsigned PORT_ELEMENT_WIDTH = 32;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] element;
      logic [5:0]  index;
   } bsd_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_element;
      logic [31:0] head_element;
      logic [31:0] tail_element;
      logic [6:0]  count;
   } bsd_rsp_type;

   // Command broadcast to every cell of the row.
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_SHIFT_UP,
      CMD_SHIFT_DOWN,
      CMD_PUT,
      CMD_CLEAR
   } bsd_cmd_type;

   // Control word seen by one cell: the shared command and whether this cell
   // is the one the tail operation addresses.
   typedef struct packed {
      bsd_cmd_type cmd;
      logic        at_tail;
   } bsd_cell_ctl_type;

endpackage

// ===== hw/rtl/bounded_shift_deque.sv =====
// ----------------------------------------------------------------------------
// Bounded shift deque
// A bounded deque kept in order in a row of cells, head in cell 0. Requests
// push or pop at either end or read an element by index; each request gives
// one response with status, read element, head, tail and count.
// ----------------------------------------------------------------------------
//
//   Channel    Ports                      Handshake
//   request    start, busy, req_item      taken when start is high, busy low
//   response   rsp_strobe, rsp_item       valid for the one strobe cycle
//
// For a request the cell row updates at the accepting edge, then the index and
// tail selectors pick their entries through two registered levels, and the
// response is shown with the result of the second level. The next request
// may be accepted in the response cycle. Reset clears all cells and the count.
// The receiver cannot stall the response.
// ----------------------------------------------------------------------------
module bounded_shift_deque #(
   parameter int CAPACITY      = 64,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  bsd_pkg::bsd_req_type req_item,
   output logic                 rsp_strobe,
   output bsd_pkg::bsd_rsp_type rsp_item
);

   localparam int PEW = bsd_pkg::PORT_ELEMENT_WIDTH;
   localparam int DW  = (ELEMENT_WIDTH < PEW) ? ELEMENT_WIDTH : PEW;
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int SW  = $clog2(CAPACITY);
   localparam int IW  = (CW > 6) ? CW : 6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GATHER,
      ST_REDUCE
   } phase_type;

   phase_type    state_ff;
   phase_type    state_in;
   logic         strobe_ff;
   logic         strobe_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [1:0]   status_ff;
   logic [1:0]   status_in;
   logic         rd_en_ff;
   logic         rd_en_in;
   logic [SW-1:0] rd_sel_ff;
   logic [SW-1:0] rd_sel_in;

   logic                  accept;
   bsd_pkg::bsd_cmd_type  cmd;
   logic [SW-1:0]         tail_pos;
   logic [CW-1:0]         count_dec;
   logic                  full;
   logic                  empty;
   logic [IW-1:0]         idx_ext;
   logic [IW-1:0]         cnt_ext;
   logic [DW-1:0]         push_value;
   logic [CW-1:0]         tail_idx;
   logic [SW-1:0]         tail_sel;
   logic [DW-1:0]         cell_value [CAPACITY];
   logic [DW-1:0]         read_value;
   logic [DW-1:0]         tail_value;

   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);
   assign full       = (count_ff == CW'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign count_dec  = count_ff - CW'(1);
   assign idx_ext    = IW'(req_item.index);
   assign cnt_ext    = IW'(count_ff);
   assign push_value = req_item.element[DW-1:0];

   // Request decode against the current fill count.
   always_comb begin
      cmd       = bsd_pkg::CMD_HOLD;
      tail_pos  = count_ff[SW-1:0];
      count_in  = count_ff;
      status_in = bsd_pkg::STATUS_DONE;
      rd_en_in  = 1'b0;
      unique case (req_item.kind)
         bsd_pkg::KIND_PUSH_HEAD: begin
            if (full) begin
               status_in = bsd_pkg::STATUS_FULL;
            end else begin
               cmd      = bsd_pkg::CMD_SHIFT_UP;
               count_in = count_ff + CW'(1);
            end
         end
         bsd_pkg::KIND_PUSH_TAIL: begin
            if (full) begin
               status_in = bsd_pkg::STATUS_FULL;
            end else begin
               cmd      = bsd_pkg::CMD_PUT;
               count_in = count_ff + CW'(1);
            end
         end
         bsd_pkg::KIND_POP_HEAD: begin
            if (empty) begin
               status_in = bsd_pkg::STATUS_EMPTY;
            end else begin
               cmd      = bsd_pkg::CMD_SHIFT_DOWN;
               count_in = count_dec;
            end
         end
         bsd_pkg::KIND_POP_TAIL: begin
            if (empty) begin
               status_in = bsd_pkg::STATUS_EMPTY;
            end else begin
               cmd      = bsd_pkg::CMD_CLEAR;
               tail_pos = count_dec[SW-1:0];
               count_in = count_dec;
            end
         end
         bsd_pkg::KIND_READ: begin
            if (idx_ext < cnt_ext) begin
               rd_en_in = 1'b1;
            end else begin
               status_in = bsd_pkg::STATUS_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   assign rd_sel_in = SW'(req_item.index);

   // Row of cells; the push value enters below cell 0 and zero above the top.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      bsd_pkg::bsd_cell_ctl_type ctl;
      logic [DW-1:0]             below;
      logic [DW-1:0]             above;

      assign ctl.cmd     = accept ? cmd : bsd_pkg::CMD_HOLD;
      assign ctl.at_tail = (tail_pos == SW'(i));

      if (i == 0) begin : g_bottom
         assign below = push_value;
      end else begin : g_mid_below
         assign below = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_top
         assign above = '0;
      end else begin : g_mid_above
         assign above = cell_value[i+1];
      end

      bsd_cell #(
         .WIDTH (DW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .below_value (below),
         .above_value (above),
         .put_value   (push_value),
         .value       (cell_value[i])
      );
   end

   // Selectors work on the updated row.
   assign tail_idx = count_ff - CW'(1);
   assign tail_sel = tail_idx[SW-1:0];

   bsd_select #(
      .DEPTH (CAPACITY),
      .WIDTH (DW)
   ) u_read_select (
      .clock   (clock),
      .entries (cell_value),
      .sel     (rd_sel_ff),
      .result  (read_value)
   );

   bsd_select #(
      .DEPTH (CAPACITY),
      .WIDTH (DW)
   ) u_tail_select (
      .clock   (clock),
      .entries (cell_value),
      .sel     (tail_sel),
      .result  (tail_value)
   );

   // Sequencer next state.
   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_GATHER;
            end
         end
         ST_GATHER: begin
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer state and per-request registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         count_ff  <= '0;
         status_ff <= bsd_pkg::STATUS_DONE;
         rd_en_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         if (accept) begin
            count_ff  <= count_in;
            status_ff <= status_in;
            rd_en_ff  <= rd_en_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_sel_ff <= rd_sel_in;
      end
   end

   // Response fields; cells above the count hold zero, so an empty head reads zero.
   assign rsp_strobe            = strobe_ff;
   assign rsp_item.status       = status_ff;
   assign rsp_item.read_element = rd_en_ff ? PEW'(read_value) : '0;
   assign rsp_item.head_element = PEW'(cell_value[0]);
   assign rsp_item.tail_element = (count_ff != '0) ? PEW'(tail_value) : '0;
   assign rsp_item.count        = 7'(count_ff);

endmodule

// ===== hw/rtl/bsd_cell.sv =====
// ----------------------------------------------------------------------------
// Bounded shift deque cell
// One storage slot of the row. It takes its lower or upper neighbor's value
// on a shift, or the pushed value or zero when it is the addressed tail cell.
// ----------------------------------------------------------------------------
module bsd_cell #(
   parameter int WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bsd_pkg::bsd_cell_ctl_type ctl,
   input  logic [WIDTH-1:0]          below_value,
   input  logic [WIDTH-1:0]          above_value,
   input  logic [WIDTH-1:0]          put_value,
   output logic [WIDTH-1:0]          value
);

   logic [WIDTH-1:0] value_ff;
   logic [WIDTH-1:0] value_in;

   // Next value for this slot.
   always_comb begin
      unique case (ctl.cmd)
         bsd_pkg::CMD_SHIFT_UP:   value_in = below_value;
         bsd_pkg::CMD_SHIFT_DOWN: value_in = above_value;
         bsd_pkg::CMD_PUT:        value_in = ctl.at_tail ? put_value : value_ff;
         bsd_pkg::CMD_CLEAR:      value_in = ctl.at_tail ? '0 : value_ff;
         default:                 value_in = value_ff;
      endcase
   end

   // Slots beyond the fill count are kept at zero, so reset clears them all.
   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// ===== hw/rtl/bsd_select.sv =====
// ----------------------------------------------------------------------------
// Bounded shift deque selector
// Picks one entry of the cell row by index through a two-level registered
// AND-OR tree: groups of 32 entries first, then the group results.
// ----------------------------------------------------------------------------
module bsd_select #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic [WIDTH-1:0]         entries [DEPTH],
   input  logic [$clog2(DEPTH)-1:0] sel,
   output logic [WIDTH-1:0]         result
);

   localparam int GROUP = 32;
   localparam int NG    = (DEPTH + GROUP - 1) / GROUP;
   localparam int PAD   = NG * GROUP;
   localparam int PW    = $clog2(PAD);

   logic [WIDTH-1:0] pad_value [PAD];
   logic [PW-1:0]    sel_ext;
   logic [WIDTH-1:0] grp_in    [NG];
   logic [WIDTH-1:0] grp_ff    [NG];
   logic [WIDTH-1:0] result_in;
   logic [WIDTH-1:0] result_ff;

   // Pad the row to whole groups with zero entries.
   for (genvar k = 0; k < PAD; k++) begin : g_pad
      if (k < DEPTH) begin : g_real
         assign pad_value[k] = entries[k];
      end else begin : g_zero
         assign pad_value[k] = '0;
      end
   end

   assign sel_ext = PW'(sel);

   // First level: each group ORs its masked entries.
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_in[g] = '0;
         for (int j = 0; j < GROUP; j++) begin
            grp_in[g] = grp_in[g] |
               ((sel_ext == PW'(g * GROUP + j)) ? pad_value[g * GROUP + j] : '0);
         end
      end
   end

   // Second level: OR of the group results.
   always_comb begin
      result_in = '0;
      for (int g = 0; g < NG; g++) begin
         result_in = result_in | grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      grp_ff    <= grp_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule
